[rtl/c93_pkg.sv]
// Shared types, constants and the symbol tables of the Code 93 run-width classifier.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package c93_pkg;

  localparam int RUN_BITS    = 12;
  localparam int NUM_RUNS    = 6;
  localparam int NUM_SYMBOLS = 48;
  localparam int SUM_W       = RUN_BITS + 3;   // six runs
  localparam int CMP_W       = RUN_BITS + 7;   // 18*width and 9*sum
  localparam int PAT_W       = 9;
  localparam int IDX_W       = 6;
  localparam int CODE_W      = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // One lane's finding: module count valid, and count minus one.
  typedef struct packed {
    logic       ok;
    logic [1:0] mods_m1;
  } lane_res_t;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    char_index;
    logic [CODE_W-1:0]   char_code;
  } result_t;

  localparam logic [PAT_W-1:0] SYM_PAT [NUM_SYMBOLS] = '{
    9'h114, 9'h148, 9'h144, 9'h142, 9'h128, 9'h124, 9'h122, 9'h150, 9'h112, 9'h10A,
    9'h1A8, 9'h1A4, 9'h1A2, 9'h194, 9'h192, 9'h18A, 9'h168, 9'h164, 9'h162, 9'h134,
    9'h11A, 9'h158, 9'h14C, 9'h146, 9'h12C, 9'h116, 9'h1B4, 9'h1B2, 9'h1AC, 9'h1A6,
    9'h196, 9'h19A, 9'h16C, 9'h166, 9'h136, 9'h13A,
    9'h12E, 9'h1D4, 9'h1D2, 9'h1CA, 9'h16E, 9'h176, 9'h1AE,
    9'h126, 9'h1DA, 9'h1D6, 9'h132, 9'h15E
  };

  // "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%abcd*"
  localparam logic [CODE_W-1:0] SYM_ASCII [NUM_SYMBOLS] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
    7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
    7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h2D, 7'h2E, 7'h20, 7'h24, 7'h2F, 7'h2B, 7'h25,
    7'h61, 7'h62, 7'h63, 7'h64, 7'h2A
  };

endpackage

[rtl/c93_if.sv]
// Valid/ready channel interfaces: six run widths in, one classification out.
// Depends on c93_pkg for widths.
`timescale 1ns / 1ps

interface c93_run_if;
  logic                         valid;
  logic                         ready;
  logic [c93_pkg::RUN_BITS-1:0] run_0;
  logic [c93_pkg::RUN_BITS-1:0] run_1;
  logic [c93_pkg::RUN_BITS-1:0] run_2;
  logic [c93_pkg::RUN_BITS-1:0] run_3;
  logic [c93_pkg::RUN_BITS-1:0] run_4;
  logic [c93_pkg::RUN_BITS-1:0] run_5;

  modport source (output valid, run_0, run_1, run_2, run_3, run_4, run_5, input ready);
  modport sink   (input valid, run_0, run_1, run_2, run_3, run_4, run_5, output ready);
endinterface

interface c93_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [c93_pkg::IDX_W-1:0]  char_index;
  logic [c93_pkg::CODE_W-1:0] char_code;

  modport source (output valid, status, char_index, char_code, input ready);
  modport sink   (input valid, status, char_index, char_code, output ready);
endinterface

[rtl/c93_lane.sv]
// One lane: turns a run width and the symbol sum into a rounded module count.
// Depends on c93_pkg.
`timescale 1ns / 1ps

module c93_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [c93_pkg::RUN_BITS-1:0] run,
  input  logic [c93_pkg::SUM_W-1:0]   sum,
  output c93_pkg::lane_res_t          res
);

  // h = floor(18*w/sum) half modules; count = ceil(h/2), valid for h in 1..8.
  logic [c93_pkg::CMP_W-1:0] w18, s1, s3, s5, s7, s9;
  c93_pkg::lane_res_t        res_nxt, res_r;

  always_comb begin
    w18 = (c93_pkg::CMP_W'(run) << 4) + (c93_pkg::CMP_W'(run) << 1);
    s1  = c93_pkg::CMP_W'(sum);
    s3  = (s1 << 1) + s1;
    s5  = (s1 << 2) + s1;
    s7  = (s1 << 3) - s1;
    s9  = (s1 << 3) + s1;
    res_nxt.ok = (w18 >= s1) && (w18 < s9);
    if (w18 >= s7) begin
      res_nxt.mods_m1 = 2'd3;
    end else if (w18 >= s5) begin
      res_nxt.mods_m1 = 2'd2;
    end else if (w18 >= s3) begin
      res_nxt.mods_m1 = 2'd1;
    end else begin
      res_nxt.mods_m1 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[rtl/c93_merge.sv]
// Merge stage: joins the six lane counts into a bar pattern and looks it up.
// Depends on c93_pkg for the symbol tables and result type.
`timescale 1ns / 1ps

module c93_merge (
  input  c93_pkg::lane_res_t lanes [c93_pkg::NUM_RUNS],
  output c93_pkg::result_t   result
);

  logic                          all_ok;
  logic [4:0]                    extra;
  logic [c93_pkg::PAT_W-1:0]     pat;
  logic [2:0]                    mods;
  logic                          found;
  logic [c93_pkg::IDX_W-1:0]     idx;

  always_comb begin
    all_ok = 1'b1;
    extra  = '0;
    pat    = '0;
    for (int i = 0; i < c93_pkg::NUM_RUNS; i++) begin
      all_ok = all_ok & lanes[i].ok;
      extra  = extra + 5'(lanes[i].mods_m1);
      mods   = 3'(lanes[i].mods_m1) + 3'd1;
      // Bars shift in ones, spaces zeros.
      pat = (pat << mods) |
            (((i % 2) == 0) ? ((c93_pkg::PAT_W'(1) << mods) - c93_pkg::PAT_W'(1))
                            : '0);
    end

    found = 1'b0;
    idx   = '0;
    for (int s = 0; s < c93_pkg::NUM_SYMBOLS; s++) begin
      if (!found && pat == c93_pkg::SYM_PAT[s]) begin
        found = 1'b1;
        idx   = c93_pkg::IDX_W'(s);
      end
    end

    // Every table entry is nine modules long; any other total cannot match.
    if (!all_ok) begin
      result.status     = c93_pkg::ST_RANGE;
      result.char_index = '0;
      result.char_code  = '0;
    end else if (extra != 5'd3 || !found) begin
      result.status     = c93_pkg::ST_NOMATCH;
      result.char_index = '0;
      result.char_code  = '0;
    end else begin
      result.status     = c93_pkg::ST_OK;
      result.char_index = idx;
      result.char_code  = c93_pkg::SYM_ASCII[idx];
    end
  end

endmodule

[rtl/code93_run_width_classifier.sv]
// Top level of the Code 93 run-width classifier: input register and sum,
// six lanes, merge stage and output register. Depends on c93_pkg, c93_if,
// c93_lane and c93_merge.
`timescale 1ns / 1ps

// Usage
//   in_ch  (sink)  : one transfer carries the six run widths of one character,
//                    bar first, alternating bar and space.
//   out_ch (source): one transfer per input item, in order: status (ok, count
//                    out of range or zero sum, pattern not in table), table
//                    index and ASCII code (both zero unless status is ok).
// Path: the input transfer loads the runs and their sum into the input
// register, then the lane counts are registered, and then the merge/lookup
// result is loaded into the output register, which drives out_ch.valid.
// Throughput: one item per cycle while out_ch is not stalled, set by the
// three-stage pipeline; each of the six lanes uses shift-add compares.
// Stalls: each stage holds while the next is full and not advancing; an empty
// stage ahead lets a new transfer in even while out_ch waits on its receiver.
// Reset (rst_n low, synchronous) empties the pipeline; no results survive.
module code93_run_width_classifier (
  input  logic      clk,
  input  logic      rst_n,
  c93_run_if.sink   in_ch,
  c93_res_if.source out_ch
);

  logic                          v1_r, v1_nxt;
  logic                          v2_r, v2_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          adv1, adv2, adv3;

  logic [c93_pkg::RUN_BITS-1:0]  run_r [c93_pkg::NUM_RUNS];
  logic [c93_pkg::RUN_BITS-1:0]  run_in [c93_pkg::NUM_RUNS];
  logic [c93_pkg::SUM_W-1:0]     sum_r, sum_nxt;

  c93_pkg::lane_res_t            lane_res [c93_pkg::NUM_RUNS];
  c93_pkg::result_t              merge_res;
  c93_pkg::result_t              res_r;

  // Advance a stage when it is empty or its content moves on.
  assign adv3 = !out_valid_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_ch.ready = adv1;

  assign run_in[0] = in_ch.run_0;
  assign run_in[1] = in_ch.run_1;
  assign run_in[2] = in_ch.run_2;
  assign run_in[3] = in_ch.run_3;
  assign run_in[4] = in_ch.run_4;
  assign run_in[5] = in_ch.run_5;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < c93_pkg::NUM_RUNS; i++) begin
      sum_nxt = sum_nxt + c93_pkg::SUM_W'(run_in[i]);
    end
    v1_nxt        = adv1 ? in_ch.valid : v1_r;
    v2_nxt        = adv2 ? v1_r : v2_r;
    out_valid_nxt = adv3 ? v2_r : out_valid_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage one: hold the runs and their sum.
  always_ff @(posedge clk) begin
    if (adv1) begin
      sum_r <= sum_nxt;
      for (int i = 0; i < c93_pkg::NUM_RUNS; i++) begin
        run_r[i] <= run_in[i];
      end
    end
  end

  // Stage two: one lane per run.
  for (genvar g = 0; g < c93_pkg::NUM_RUNS; g++) begin : g_lane
    c93_lane u_lane (
      .clk (clk),
      .en  (adv2),
      .run (run_r[g]),
      .sum (sum_r),
      .res (lane_res[g])
    );
  end

  // Stage three: combine the lanes and look up the symbol.
  c93_merge u_merge (
    .lanes  (lane_res),
    .result (merge_res)
  );

  always_ff @(posedge clk) begin
    if (adv3) begin
      res_r <= merge_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.char_index = res_r.char_index;
  assign out_ch.char_code  = res_r.char_code;

endmodule
